FILE: design/esd_pkg.sv
// esd_pkg: shared types for the escape sequence decoder
// decode state encoding and the result entry carried from decoder to queue
// no dependencies
`timescale 1ns / 1ps

package esd_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_HEX    = 2'd2,
      MODE_OCT    = 2'd3
   } decode_mode_type;

   localparam logic [7:0] BACKSLASH      = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;
   localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;

   // one decoded byte with its end-of-transaction and end-of-text flags
   typedef struct packed {
      logic       text_done;
      logic       run_done;
      logic [7:0] data;
   } rsp_item_type;

   // up to two results produced by one input transaction
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

FILE: design/esd_decode.sv
// esd_decode: escape decoding state and next-state logic
// turns one raw byte into zero, one or two decoded results per transaction
// depends on esd_pkg
`timescale 1ns / 1ps

module esd_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_fire,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output esd_pkg::push_type push
);
   import esd_pkg::*;

   decode_mode_type mode_ff, mode_in;
   logic [7:0]      value_ff, value_in;
   logic [1:0]      count_ff, count_in;

   logic [1:0] n_res;
   logic [7:0] byte0;
   logic [7:0] byte1;

   // 0..15 for a hex digit, bit 4 set otherwise
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = {1'b0, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         v = {1'b0, b[3:0] + 4'd9};
      end
      return v;
   endfunction

   function automatic logic [7:0] map_escape(input logic [7:0] b);
      logic [7:0] m;
      case (b)
         8'h61:   m = 8'h07;
         8'h62:   m = 8'h08;
         8'h66:   m = 8'h0C;
         8'h6E:   m = 8'h0A;
         8'h72:   m = 8'h0D;
         8'h74:   m = 8'h09;
         8'h76:   m = 8'h0B;
         default: m = b;
      endcase
      return m;
   endfunction

   logic [4:0] hex_d;
   logic       is_oct;
   logic       nb_esc;
   logic       nb_emit;
   logic [7:0] acc_hex;
   logic [7:0] acc_oct;
   logic [1:0] cnt_inc;

   assign hex_d   = hex_value(in_byte);
   assign is_oct  = (in_byte[7:3] == 5'b00110);
   // a backslash opens an escape unless it is the last byte of the text
   assign nb_esc  = (in_byte == BACKSLASH) && !in_last;
   assign nb_emit = !nb_esc;
   assign acc_hex = {value_ff[3:0], hex_d[3:0]};
   assign acc_oct = {value_ff[4:0], in_byte[2:0]};
   assign cnt_inc = count_ff + 2'd1;

   always_comb begin
      mode_in  = mode_ff;
      value_in = value_ff;
      count_in = count_ff;
      n_res    = 2'd0;
      byte0    = 8'h00;
      byte1    = in_byte;
      case (mode_ff)
         MODE_NORMAL: begin
            if (nb_emit) begin
               n_res = 2'd1;
               byte0 = in_byte;
            end
            if (nb_esc) begin
               mode_in = MODE_ESC;
            end
         end
         MODE_ESC: begin
            if (in_byte == CHAR_X) begin
               mode_in  = MODE_HEX;
               value_in = 8'h00;
               count_in = 2'd0;
               if (in_last) begin
                  n_res = 2'd1;
                  byte0 = 8'h00;
               end
            end else if (is_oct) begin
               mode_in  = MODE_OCT;
               value_in = {5'd0, in_byte[2:0]};
               count_in = 2'd1;
               if (in_last) begin
                  n_res = 2'd1;
                  byte0 = {5'd0, in_byte[2:0]};
               end
            end else begin
               mode_in = MODE_NORMAL;
               n_res   = 2'd1;
               byte0   = map_escape(in_byte);
            end
         end
         MODE_HEX: begin
            if (!hex_d[4]) begin
               value_in = acc_hex;
               count_in = cnt_inc;
               if (cnt_inc >= HEX_DIGITS_MAX || in_last) begin
                  n_res    = 2'd1;
                  byte0    = acc_hex;
                  mode_in  = MODE_NORMAL;
                  value_in = 8'h00;
                  count_in = 2'd0;
               end
            end else begin
               // terminator: flush the value, then treat the byte as ordinary
               n_res    = nb_emit ? 2'd2 : 2'd1;
               byte0    = value_ff;
               mode_in  = nb_esc ? MODE_ESC : MODE_NORMAL;
               value_in = 8'h00;
               count_in = 2'd0;
            end
         end
         default: begin
            if (is_oct) begin
               value_in = acc_oct;
               count_in = cnt_inc;
               if (cnt_inc >= OCT_DIGITS_MAX || in_last) begin
                  n_res    = 2'd1;
                  byte0    = acc_oct;
                  mode_in  = MODE_NORMAL;
                  value_in = 8'h00;
                  count_in = 2'd0;
               end
            end else begin
               n_res    = nb_emit ? 2'd2 : 2'd1;
               byte0    = value_ff;
               mode_in  = nb_esc ? MODE_ESC : MODE_NORMAL;
               value_in = 8'h00;
               count_in = 2'd0;
            end
         end
      endcase
      if (in_last) begin
         mode_in  = MODE_NORMAL;
         value_in = 8'h00;
         count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         value_ff <= 8'h00;
         count_ff <= 2'd0;
      end else if (in_fire) begin
         mode_ff  <= mode_in;
         value_ff <= value_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      push.count            = in_fire ? n_res : 2'd0;
      push.first.data       = byte0;
      push.first.run_done   = (n_res == 2'd1);
      push.first.text_done  = (n_res == 2'd1) && in_last;
      push.second.data      = byte1;
      push.second.run_done  = 1'b1;
      push.second.text_done = in_last;
   end

endmodule

FILE: design/esd_queue.sv
// esd_queue: small result queue between decoder and output channel
// takes up to two entries per cycle, delivers one per cycle while out_ready is high
// depends on esd_pkg
`timescale 1ns / 1ps

module esd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  esd_pkg::push_type     push,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output esd_pkg::rsp_item_type out_item
);
   import esd_pkg::*;

   localparam int DEPTH = 4;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type mem [DEPTH];

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (fill_ff != '0);
   assign out_item  = mem[head_ff];
   // room for the worst case of two results from the next transaction
   assign room      = (fill_ff <= CNT_W'(DEPTH - 2));

   assign head_in = head_ff + IDX_W'(pop);
   assign tail_in = tail_ff + IDX_W'(push.count);
   assign fill_in = fill_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[tail_ff + IDX_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

endmodule

FILE: design/escape_sequence_decoder.sv
// escape_sequence_decoder: c string escape decoding, one raw byte per cycle
//   while the queue has room for two results; each result is written into the queue on acceptance
// and offered from its head; a byte that yields two results (numeric escape
//   closed by another byte) writes both entries at once, absorbed by a 4-entry queue
// reset: synchronous, active high; clears decode mode, accumulator and queue
`timescale 1ns / 1ps

module escape_sequence_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // run_done
   output logic       rsp_tuser    // [0] text_done
);
   import esd_pkg::*;

   push_type     push;
   rsp_item_type head_item;
   logic         req_fire;

   assign req_fire = req_tvalid && req_tready;

   esd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .in_fire (req_fire),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .push    (push)
   );

   esd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head_item)
   );

   assign rsp_tdata = head_item.data;
   assign rsp_tlast = head_item.run_done;
   assign rsp_tuser = head_item.text_done;

endmodule

FILE: design/esd_checker.sv
// esd_checker: port-level checks for the escape sequence decoder
// bound to escape_sequence_decoder; no package dependency
`timescale 1ns / 1ps

module esd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // end of text is always the last result of its transaction
   a_text_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("text_done without run_done");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                      && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // a waiting input transaction holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)
                                      && $stable(req_tlast)))
      else $error("waiting input changed");

   // input only backs up while results wait
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty result queue");

   // queue is empty straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

FILE: sim/escape_sequence_decoder_tb.sv
// escape_sequence_decoder_tb: self-checking bench for the c escape sequence decoder
// drives raw string bytes with random gaps and stalls, predicts the decoded bytes
// depends on esd_pkg and escape_sequence_decoder
`timescale 1ns / 1ps

module escape_sequence_decoder_tb;
   import esd_pkg::*;

   class esc_decode_checker;
      decode_mode_type mode;
      logic [7:0]      acc;
      logic [1:0]      digits;
      rsp_item_type    step_q[$];
      rsp_item_type    decoded_q[$];
      int              fail_count;

      function new();
         clear_state();
         fail_count = 0;
      endfunction

      function void clear_state();
         mode   = MODE_NORMAL;
         acc    = 8'h00;
         digits = 2'd0;
      endfunction

      function void emit(logic [7:0] d);
         rsp_item_type item;
         item.data      = d;
         item.run_done  = 1'b0;
         item.text_done = 1'b0;
         step_q.push_back(item);
      endfunction

      function void plain_byte(logic [7:0] raw, logic eot);
         if (raw == BACKSLASH) begin
            if (eot) emit(BACKSLASH);
            else mode = MODE_ESC;
         end else begin
            emit(raw);
         end
      endfunction

      // works out the decoded bytes caused by one accepted raw byte
      function void note_raw(logic [7:0] raw, logic eot);
         logic [3:0] nib;
         logic       is_hex;
         step_q.delete();
         case (mode)
            MODE_NORMAL: plain_byte(raw, eot);
            MODE_ESC: begin
               if (raw == CHAR_X) begin
                  mode   = MODE_HEX;
                  acc    = 8'h00;
                  digits = 2'd0;
                  if (eot) emit(8'h00);
               end else if (raw >= "0" && raw <= "7") begin
                  mode   = MODE_OCT;
                  acc    = {5'd0, raw[2:0]};
                  digits = 2'd1;
                  if (eot) emit(acc);
               end else begin
                  mode = MODE_NORMAL;
                  case (raw)
                     "a":     emit(8'h07);
                     "b":     emit(8'h08);
                     "f":     emit(8'h0C);
                     "n":     emit(8'h0A);
                     "r":     emit(8'h0D);
                     "t":     emit(8'h09);
                     "v":     emit(8'h0B);
                     default: emit(raw);
                  endcase
               end
            end
            MODE_HEX: begin
               is_hex = 1'b1;
               nib    = 4'd0;
               if (raw >= "0" && raw <= "9") nib = 4'(raw - "0");
               else if (raw >= "a" && raw <= "f") nib = 4'(raw - "a" + 10);
               else if (raw >= "A" && raw <= "F") nib = 4'(raw - "A" + 10);
               else is_hex = 1'b0;
               if (is_hex) begin
                  acc    = {acc[3:0], nib};
                  digits = digits + 2'd1;
                  if (digits >= HEX_DIGITS_MAX || eot) begin
                     emit(acc);
                     clear_state();
                  end
               end else begin
                  emit(acc);
                  clear_state();
                  plain_byte(raw, eot);
               end
            end
            default: begin
               if (raw >= "0" && raw <= "7") begin
                  acc    = {acc[4:0], raw[2:0]};
                  digits = digits + 2'd1;
                  if (digits >= OCT_DIGITS_MAX || eot) begin
                     emit(acc);
                     clear_state();
                  end
               end else begin
                  emit(acc);
                  clear_state();
                  plain_byte(raw, eot);
               end
            end
         endcase
         if (eot) clear_state();
         if (step_q.size() > 0) begin
            step_q[step_q.size()-1].run_done  = 1'b1;
            step_q[step_q.size()-1].text_done = eot;
         end
         foreach (step_q[i]) decoded_q.push_back(step_q[i]);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         fail_count++;
      endtask

      task check_decoded(logic [7:0] data, logic last, logic user);
         rsp_item_type exp_item;
         if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result data %02h", data));
         end else begin
            exp_item = decoded_q.pop_front();
            if (data !== exp_item.data)
               report_mismatch($sformatf("out_byte %02h, wanted %02h", data, exp_item.data));
            if (last !== exp_item.run_done)
               report_mismatch($sformatf("run_done %b, wanted %b", last, exp_item.run_done));
            if (user !== exp_item.text_done)
               report_mismatch($sformatf("text_done %b, wanted %b", user, exp_item.text_done));
         end
      endtask

      function int pending();
         return decoded_q.size();
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 300000;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] in_byte
   logic       req_tlast;   // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic       rsp_tlast;   // run_done
   logic       rsp_tuser;   // [0] text_done

   esc_decode_checker checker_h = new();
   int  cycle_count = 0;
   int  sent_count  = 0;
   bit  tx_calm     = 0;
   logic [7:0] esc_set [11] = '{"a", "b", "f", "n", "r", "t", "v", "?", "'", "\"", "\\"};

   escape_sequence_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         checker_h.check_decoded(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // receiver: random stall before each result, with calm stretches
   initial begin
      int gap;
      int taken;
      bit rx_calm;
      rsp_tready = 1'b0;
      taken      = 0;
      rx_calm    = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (taken % 30 == 0) rx_calm = ($urandom_range(0, 2) == 0);
         gap = rx_calm ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // valid stays high between back-to-back transactions
   task send_raw(logic [7:0] raw, logic eot);
      int gap;
      if (sent_count % 30 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      gap = tx_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      checker_h.note_raw(raw, eot);
      sent_count++;
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (checker_h.pending() > 0) @(posedge clock);
   endtask

   function logic [7:0] rand_hex_digit();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
   endfunction

   // one string built from random tokens, mostly well-formed escapes
   task send_text();
      logic [7:0] seq[$];
      int tokens;
      int kind;
      int n;
      logic [7:0] v;
      tokens = $urandom_range(1, 10);
      repeat (tokens) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               do v = 8'($urandom_range(0, 255)); while (v == BACKSLASH);
               seq.push_back(v);
            end
            3: begin
               seq.push_back(BACKSLASH);
               seq.push_back(esc_set[$urandom_range(0, 10)]);
            end
            4: begin
               seq.push_back(BACKSLASH);
               seq.push_back(8'($urandom_range(0, 255)));
            end
            5, 6: begin
               seq.push_back(BACKSLASH);
               seq.push_back(CHAR_X);
               n = $urandom_range(0, 3);
               repeat (n) seq.push_back(rand_hex_digit());
            end
            7, 8: begin
               seq.push_back(BACKSLASH);
               n = $urandom_range(1, 4);
               repeat (n) seq.push_back(8'("0" + $urandom_range(0, 7)));
            end
            default: seq.push_back(BACKSLASH);
         endcase
      end
      foreach (seq[i]) send_raw(seq[i], i == seq.size() - 1);
   endtask

   initial begin
      bit paused;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      paused     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full hex escape, then hex escape with no digits
      send_raw(BACKSLASH, 0); send_raw(CHAR_X, 0); send_raw("4", 0); send_raw("1", 0);
      send_raw(BACKSLASH, 0); send_raw(CHAR_X, 0); send_raw("g", 0);
      // three octal digits wrapping past 8 bits
      send_raw(BACKSLASH, 0); send_raw("7", 0); send_raw("7", 0); send_raw("7", 0);
      // octal zero ended by a non-octal digit
      send_raw(BACKSLASH, 0); send_raw("0", 0); send_raw("8", 0);
      send_raw(BACKSLASH, 0); send_raw("n", 0);
      // octal escape ended by a backslash that also ends the text
      send_raw(BACKSLASH, 0); send_raw("5", 0); send_raw(BACKSLASH, 1);
      // escape cut by end on the x, then lone backslash at end
      send_raw(BACKSLASH, 0); send_raw(CHAR_X, 1);
      send_raw(BACKSLASH, 1);
      // zero byte is ordinary, all-ones byte ends a text
      send_raw(8'h00, 0); send_raw(8'hFF, 1);

      wait_drained();

      while (sent_count < 395) begin
         send_text();
         if (!paused && sent_count >= 200) begin
            wait_drained();
            paused = 1;
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (checker_h.fail_count == 0 && checker_h.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/esd_pkg.sv
design/esd_decode.sv
design/esd_queue.sv
design/escape_sequence_decoder.sv
design/esd_checker.sv
sim/escape_sequence_decoder_tb.sv
